@@ rtl/core/wrrhp_pkg.sv @@
// Shared types and constants for the weighted round robin health picker.
// No dependencies.
`timescale 1ns / 1ps
package wrrhp_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_PICK   = 2'd1;
   localparam logic [1:0] CMD_REPORT = 2'd2;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_PROBE   = 3'd1;
   localparam logic [2:0] KIND_PRIMARY = 3'd2;
   localparam logic [2:0] KIND_SPARE   = 3'd3;
   localparam logic [2:0] KIND_ROTATE  = 3'd4;

   localparam logic [1:0] OUT_OK      = 2'd0;
   localparam logic [1:0] OUT_FULL    = 2'd1;
   localparam logic [1:0] OUT_NO_TGT  = 2'd2;

   localparam logic [4:0] BACKOFF_CAP    = 5'd30;
   localparam logic [9:0] SERVER_ERR_MIN = 10'd500;
   localparam int         LONE_COUNT     = 1;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] time_seconds;
      logic [7:0]  peer_key;
      logic [9:0]  http_status;
      logic [7:0]  set_weight;
      logic [7:0]  set_fail_limit;
      logic [15:0] set_fail_window;
      logic        is_spare;
   } item_type;

   typedef struct packed {
      logic       valid;
      item_type   item;
   } head_type;

endpackage

@@ rtl/core/wrrhp_front.sv @@
// Front end: accepts command beats into a two-deep queue for the engine.
// Depends on wrrhp_pkg.
`timescale 1ns / 1ps
module wrrhp_front
   import wrrhp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  item_type req_item,
   output logic     busy,
   input  logic     pop,
   output head_type head
);

   item_type   q_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = (pop && head.valid) ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop && head.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= req_item;
   end

endmodule

@@ rtl/core/wrrhp_engine.sv @@
// Back end: target tables and the sequencer that walks them for add, pick
// and report, with a shared bit-serial divider. Depends on wrrhp_pkg.
`timescale 1ns / 1ps
module wrrhp_engine
   import wrrhp_pkg::*;
#(
   parameter int PRIMARY_SLOTS = 8,
   parameter int SPARE_SLOTS   = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   output logic       rsp_strobe,
   output logic [7:0] rsp_picked_key,
   output logic [2:0] rsp_pick_kind,
   output logic [1:0] rsp_outcome
);

   localparam int TOT  = PRIMARY_SLOTS + SPARE_SLOTS;
   localparam int MAXS = (PRIMARY_SLOTS > SPARE_SLOTS) ? PRIMARY_SLOTS : SPARE_SLOTS;
   localparam int SW   = $clog2(TOT);
   localparam int CW   = $clog2(MAXS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_PROBE, S_CH_START, S_CHOOSE, S_WFIN,
      S_ROTATE, S_DIV, S_ROT_OUT, S_FIND, S_UPD
   } state_type;

   logic [7:0]  tk [TOT];
   logic [7:0]  tw [TOT];
   logic [7:0]  tl [TOT];
   logic [15:0] twin [TOT];
   logic        dn [TOT];
   logic [7:0]  fc [TOT];
   logic [4:0]  bo [TOT];
   logic [7:0]  ew [TOT];
   logic [15:0] cw [TOT];
   logic [31:0] ck [TOT];
   logic [31:0] ac [TOT];

   state_type   state_ff;
   item_type    cur_ff;
   logic [CW-1:0] pc_ff, sc_ff, idx_ff;
   logic        bank_ff;
   logic [SW-1:0] found_ff, best_ff, hit_ff;
   logic        found_v_ff, best_v_ff, div_rot_ff;
   logic [15:0] best_cw_ff, total_ff;
   logic [31:0] rot_ff;
   logic [31:0] div_q_ff;
   logic [7:0]  div_r_ff, div_n_ff;
   logic [5:0]  div_cnt_ff;
   logic        strobe_ff;
   logic [7:0]  key_ff;
   logic [2:0]  kind_ff;
   logic [1:0]  outc_ff;

   logic [CW-1:0] n_w;
   logic [SW-1:0] slot_w, base_w;
   logic [32:0]   diff_w, diff_best_w;
   logic [20:0]   backoff_w;
   logic          expired_w, skip_w;
   logic [15:0]   ncw_w;
   logic [8:0]    div_r2_w;
   logic          div_ge_w;
   logic [31:0]   rot_next_w;

   assign pop = (state_ff == S_IDLE) && head.valid;
   assign rsp_strobe     = strobe_ff;
   assign rsp_picked_key = key_ff;
   assign rsp_pick_kind  = kind_ff;
   assign rsp_outcome    = outc_ff;

   always_comb begin
      n_w    = bank_ff ? sc_ff : pc_ff;
      base_w = bank_ff ? SW'(PRIMARY_SLOTS) : '0;
      slot_w = base_w + SW'(idx_ff);
      diff_w = {1'b0, cur_ff.time_seconds} - {1'b0, ck[slot_w]};
      diff_best_w = {1'b0, cur_ff.time_seconds} - {1'b0, ck[best_ff]};
      backoff_w = bo[slot_w] * twin[slot_w];
      expired_w = $signed(diff_w) > $signed({12'd0, backoff_w});
      skip_w = dn[slot_w] || ((tl[slot_w] != 8'd0) && (fc[slot_w] >= tl[slot_w]) &&
               !($signed(diff_w) > $signed({17'd0, twin[slot_w]})));
      ncw_w  = cw[slot_w] + {8'd0, ew[slot_w]};
      div_r2_w = {div_r_ff, div_q_ff[31]};
      div_ge_w = div_r2_w >= {1'b0, div_n_ff};
      rot_next_w = rot_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pc_ff     <= '0;
         sc_ff     <= '0;
         rot_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               // result beat lasts exactly the one cycle spent here
               strobe_ff <= 1'b0;
               if (head.valid) begin
                  cur_ff   <= head.item;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               key_ff  <= 8'd0;
               kind_ff <= KIND_NONE;
               bank_ff <= 1'b0;
               idx_ff  <= '0;
               found_v_ff <= 1'b0;
               case (cur_ff.command)
                  CMD_ADD: begin
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                     if (cur_ff.is_spare ? (sc_ff >= CW'(SPARE_SLOTS))
                                         : (pc_ff >= CW'(PRIMARY_SLOTS))) begin
                        outc_ff <= OUT_FULL;
                     end else begin
                        outc_ff <= OUT_OK;
                        if (cur_ff.is_spare) sc_ff <= sc_ff + 1'b1;
                        else                 pc_ff <= pc_ff + 1'b1;
                        tk[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= cur_ff.peer_key;
                        tw[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= cur_ff.set_weight;
                        tl[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= cur_ff.set_fail_limit;
                        twin[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= cur_ff.set_fail_window;
                        dn[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= 1'b0;
                        fc[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= 8'd0;
                        bo[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= 5'd1;
                        ew[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= cur_ff.set_weight;
                        cw[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= 16'd0;
                        ck[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= 32'd0;
                        ac[cur_ff.is_spare ? SW'(PRIMARY_SLOTS) + SW'(sc_ff) : SW'(pc_ff)]
                           <= 32'd0;
                     end
                  end
                  CMD_PICK: begin
                     if (pc_ff == '0 && sc_ff == '0) begin
                        outc_ff   <= OUT_NO_TGT;
                        strobe_ff <= 1'b1;
                        state_ff  <= S_IDLE;
                     end else begin
                        outc_ff  <= OUT_OK;
                        state_ff <= S_PROBE;
                     end
                  end
                  CMD_REPORT: begin
                     outc_ff  <= OUT_OK;
                     state_ff <= S_FIND;
                  end
                  default: begin
                     outc_ff   <= OUT_OK;
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               endcase
            end
            S_PROBE: begin
               if (idx_ff == n_w) begin
                  if (found_v_ff) begin
                     key_ff    <= tk[found_ff];
                     kind_ff   <= KIND_PROBE;
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end else if (!bank_ff) begin
                     bank_ff <= 1'b1;
                     idx_ff  <= '0;
                  end else begin
                     bank_ff  <= 1'b0;
                     state_ff <= S_CH_START;
                  end
               end else if (!dn[slot_w]) begin
                  // an up entry cancels probing of both banks
                  bank_ff  <= 1'b0;
                  state_ff <= S_CH_START;
               end else begin
                  if (expired_w) begin
                     ck[slot_w] <= cur_ff.time_seconds;
                     found_ff   <= slot_w;
                     found_v_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_CH_START: begin
               idx_ff     <= '0;
               best_v_ff  <= 1'b0;
               total_ff   <= 16'd0;
               if (n_w == CW'(LONE_COUNT)) begin
                  if (!dn[base_w]) begin
                     key_ff    <= tk[base_w];
                     kind_ff   <= bank_ff ? KIND_SPARE : KIND_PRIMARY;
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end else if (!bank_ff) begin
                     bank_ff <= 1'b1;
                  end else begin
                     state_ff <= S_ROTATE;
                  end
               end else if (n_w == '0) begin
                  if (!bank_ff) bank_ff <= 1'b1;
                  else          state_ff <= S_ROTATE;
               end else begin
                  state_ff <= S_CHOOSE;
               end
            end
            S_CHOOSE: begin
               if (idx_ff == n_w) begin
                  state_ff <= S_WFIN;
               end else begin
                  if (!skip_w) begin
                     cw[slot_w] <= ncw_w;
                     total_ff   <= total_ff + {8'd0, ew[slot_w]};
                     if (ew[slot_w] < tw[slot_w]) ew[slot_w] <= ew[slot_w] + 8'd1;
                     if (!best_v_ff || ($signed(ncw_w) > $signed(best_cw_ff))) begin
                        best_ff    <= slot_w;
                        best_cw_ff <= ncw_w;
                        best_v_ff  <= 1'b1;
                     end
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_WFIN: begin
               if (best_v_ff) begin
                  cw[best_ff] <= cw[best_ff] - total_ff;
                  if ($signed(diff_best_w) > $signed({17'd0, twin[best_ff]}))
                     ck[best_ff] <= cur_ff.time_seconds;
                  key_ff    <= tk[best_ff];
                  kind_ff   <= bank_ff ? KIND_SPARE : KIND_PRIMARY;
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else if (!bank_ff) begin
                  bank_ff  <= 1'b1;
                  state_ff <= S_CH_START;
               end else begin
                  state_ff <= S_ROTATE;
               end
            end
            S_ROTATE: begin
               for (int i = 0; i < TOT; i++) begin
                  if ((i < PRIMARY_SLOTS && i < int'(pc_ff)) ||
                      (i >= PRIMARY_SLOTS && (i - PRIMARY_SLOTS) < int'(sc_ff))) begin
                     fc[i] <= 8'd0;
                     bo[i] <= 5'd1;
                  end
               end
               rot_ff <= rot_next_w;
               bank_ff <= (sc_ff != '0 && rot_next_w[0]) || (pc_ff == '0);
               div_n_ff <= 8'(((sc_ff != '0 && rot_next_w[0]) || (pc_ff == '0))
                              ? sc_ff : pc_ff);
               div_q_ff   <= rot_next_w;
               div_r_ff   <= 8'd0;
               div_cnt_ff <= 6'd32;
               div_rot_ff <= 1'b1;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               div_r_ff   <= div_ge_w ? 8'(div_r2_w - {1'b0, div_n_ff}) : div_r2_w[7:0];
               div_q_ff   <= {div_q_ff[30:0], div_ge_w};
               div_cnt_ff <= div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd1) state_ff <= div_rot_ff ? S_ROT_OUT : S_UPD;
            end
            S_ROT_OUT: begin
               key_ff    <= tk[base_w + SW'(div_r_ff)];
               kind_ff   <= KIND_ROTATE;
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            S_FIND: begin
               if (idx_ff == n_w) begin
                  if (!bank_ff) begin
                     bank_ff <= 1'b1;
                     idx_ff  <= '0;
                  end else begin
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end else if (tk[slot_w] == cur_ff.peer_key) begin
                  hit_ff <= slot_w;
                  if (cur_ff.http_status >= SERVER_ERR_MIN && !dn[slot_w] &&
                      tl[slot_w] != 8'd0) begin
                     // weight cut = weight / fail limit
                     div_q_ff   <= {tw[slot_w], 24'd0};
                     div_n_ff   <= tl[slot_w];
                     div_r_ff   <= 8'd0;
                     div_cnt_ff <= 6'd8;
                     div_rot_ff <= 1'b0;
                     state_ff   <= S_DIV;
                  end else begin
                     state_ff <= S_UPD;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_UPD: begin
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
               if (cur_ff.http_status >= SERVER_ERR_MIN) begin
                  ck[hit_ff] <= cur_ff.time_seconds;
                  ac[hit_ff] <= cur_ff.time_seconds;
                  if (dn[hit_ff]) begin
                     if (bo[hit_ff] < BACKOFF_CAP) bo[hit_ff] <= bo[hit_ff] + 5'd1;
                  end else begin
                     fc[hit_ff] <= (fc[hit_ff] == 8'hFF) ? 8'hFF : fc[hit_ff] + 8'd1;
                     if (tl[hit_ff] != 8'd0)
                        ew[hit_ff] <= (ew[hit_ff] > div_q_ff[7:0]) ?
                                      ew[hit_ff] - div_q_ff[7:0] : 8'd0;
                     if (((fc[hit_ff] == 8'hFF) ? 8'hFF : fc[hit_ff] + 8'd1) >=
                         tl[hit_ff]) begin
                        dn[hit_ff] <= 1'b1;
                        bo[hit_ff] <= 5'd1;
                     end
                  end
               end else begin
                  // a revive below clears the fail count anyway
                  if (ac[hit_ff] < ck[hit_ff] && !(dn[hit_ff] && bo[hit_ff] <= 5'd1))
                     fc[hit_ff] <= 8'd0;
                  if (dn[hit_ff]) begin
                     if (bo[hit_ff] <= 5'd1) begin
                        dn[hit_ff] <= 1'b0;
                        bo[hit_ff] <= 5'd1;
                        fc[hit_ff] <= 8'd0;
                        ew[hit_ff] <= tw[hit_ff];
                        cw[hit_ff] <= 16'd0;
                        ac[hit_ff] <= 32'd0;
                        ck[hit_ff] <= 32'd0;
                     end else begin
                        bo[hit_ff] <= (bo[hit_ff] >> 1) != 5'd0 ? (bo[hit_ff] >> 1) : 5'd1;
                        ck[hit_ff] <= cur_ff.time_seconds;
                        ac[hit_ff] <= cur_ff.time_seconds;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/weighted_round_robin_health_picker_unit.sv @@
// A pick walks the probe pass, then the weighted walks over both banks, then a bit-serial
// remainder for the rotation fallback; a report walks both banks for the key.
// One command in the engine, two queued; busy while the queue is full.
// The engine takes one command at a time and walks its entries one per cycle.
// Synchronous reset clears bank counts, rotation counter and queue; tables stay
// undefined until added. Results cannot be stalled. Uses wrrhp_pkg, front, engine.
`timescale 1ns / 1ps
module weighted_round_robin_health_picker_unit
   import wrrhp_pkg::*;
#(
   parameter int PRIMARY_SLOTS = 8,
   parameter int SPARE_SLOTS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_time_seconds,
   input  logic [7:0]  req_peer_key,
   input  logic [9:0]  req_http_status,
   input  logic [7:0]  req_set_weight,
   input  logic [7:0]  req_set_fail_limit,
   input  logic [15:0] req_set_fail_window,
   input  logic        req_is_spare,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_picked_key,
   output logic [2:0]  rsp_pick_kind,
   output logic [1:0]  rsp_outcome
);

   item_type req_item;
   head_type head;
   logic     pop;

   assign req_item = '{command: req_command, time_seconds: req_time_seconds,
                       peer_key: req_peer_key, http_status: req_http_status,
                       set_weight: req_set_weight, set_fail_limit: req_set_fail_limit,
                       set_fail_window: req_set_fail_window, is_spare: req_is_spare};

   wrrhp_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .pop(pop), .head(head)
   );

   wrrhp_engine #(.PRIMARY_SLOTS(PRIMARY_SLOTS), .SPARE_SLOTS(SPARE_SLOTS)) u_engine (
      .clock(clock), .reset(reset), .head(head), .pop(pop),
      .rsp_strobe(rsp_strobe), .rsp_picked_key(rsp_picked_key),
      .rsp_pick_kind(rsp_pick_kind), .rsp_outcome(rsp_outcome)
   );

endmodule

@@ rtl/core/wrrhp_checker.sv @@
// Port-level checks on the health picker's result beats, bound to the top.
// Depends on wrrhp_pkg and weighted_round_robin_health_picker_unit.
`timescale 1ns / 1ps
module wrrhp_checker
   import wrrhp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_strobe,
   input logic [7:0] rsp_picked_key,
   input logic [2:0] rsp_pick_kind,
   input logic [1:0] rsp_outcome
);

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result beats back to back");

   a_none_zero_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pick_kind == KIND_NONE) |-> rsp_picked_key == 8'd0)
      else $error("key without pick");

   a_fail_no_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_outcome != OUT_OK) |-> rsp_pick_kind == KIND_NONE)
      else $error("kind on failed beat");

endmodule

bind weighted_round_robin_health_picker_unit wrrhp_checker u_wrrhp_checker (
   .clock(clock), .reset(reset), .rsp_strobe(rsp_strobe),
   .rsp_picked_key(rsp_picked_key), .rsp_pick_kind(rsp_pick_kind),
   .rsp_outcome(rsp_outcome)
);
